@@ design/nsd_pkg.sv @@
// Shared types and constants of the netpbm stream decoder.
package nsd_pkg;

    localparam logic [7:0]  ASCII_ZERO  = 8'd48;
    localparam logic [7:0]  DIGIT_LOW   = 8'd47;
    localparam logic [7:0]  DIGIT_HIGH  = 8'd58;
    localparam logic [7:0]  ASCII_P     = 8'h50;
    localparam logic [7:0]  ASCII_ONE   = 8'h31;
    localparam logic [7:0]  ASCII_TWO   = 8'h32;
    localparam logic [7:0]  ASCII_THREE = 8'h33;
    localparam logic [7:0]  ASCII_SIX   = 8'h36;
    localparam logic [7:0]  FULL_LEVEL  = 8'd255;
    localparam logic [16:0] ACC_MAX     = 17'd131071;
    localparam logic [16:0] ACC_GUARD   = 17'd13107;
    localparam logic [15:0] LEVEL_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_BAD_MAGIC,
        ST_BAD_FORMAT,
        ST_ZERO_LEVEL
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [16:0] sample;
        logic [15:0] level;
    } t_scale_req;

    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } t_scale_rsp;

endpackage

@@ design/nsd_scale.sv @@
// Iterative sample scaler: sample*255/level, one quotient bit per cycle.
module nsd_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nsd_pkg::t_scale_req i_req,
    output nsd_pkg::t_scale_rsp o_rsp
);
    import nsd_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [23:0] r_rem;
    logic [22:0] r_dvs;
    logic [7:0]  r_quo;

    logic        w_sat;
    logic [23:0] w_num;
    logic [23:0] w_dvs_ext;
    logic        w_ge;

    // saturate when the level is zero or the sample exceeds it
    assign w_sat     = (i_req.level == 16'd0) || (i_req.sample > {1'b0, i_req.level});
    // v*255 = (v<<8) - v
    assign w_num     = {i_req.sample[15:0], 8'd0} - {8'd0, i_req.sample[15:0]};
    assign w_dvs_ext = {1'b0, r_dvs};
    assign w_ge      = r_rem >= w_dvs_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 3'd0;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division datapath; quotient fits 8 bits since sample <= level
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= w_num;
            r_dvs <= {i_req.level, 7'd0};
            r_quo <= w_sat ? FULL_LEVEL : 8'd0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - w_dvs_ext;
            end
            r_quo <= {r_quo[6:0], w_ge};
            r_dvs <= {1'b0, r_dvs[22:1]};
        end
    end

    always_comb begin
        o_rsp.done  = r_done;
        o_rsp.value = r_quo;
    end

endmodule

@@ design/netpbm_stream_decoder_unit.sv @@
// Top level of the netpbm stream decoder: header parser, pixel assembler, output register.
//
// Usage:
//   Input channel carries one file byte per transaction (data_byte plus an
//   end_of_file flag on the last byte). Output channel carries one result per
//   transaction: a pixel with row, column and RGB, or an error status with
//   all other fields zero. Both channels use valid/stall handshakes.
//
// Processing:
//   A byte that yields no result and needs no scaling leaves the block idle,
//   so the next byte can be accepted in the following cycle. A result
//   without scaling (P1 pixel, error) passes the emit state into the output
//   register. A scaled sample runs 8 radix-2 steps in the shared scaler unit
//   (divide by the maximum level; 255 without steps when saturated), is handed
//   off, and for a gray or blue sample loads the output register.
//
// Stall: the output register holds a finished result while the receiver
//   stalls; the block keeps accepting bytes until it has another result to
//   load, then waits in its emit state with the input stalled.
// Reset: synchronous, active low; parser returns to expecting the magic
//   letter and the output register empties. end_of_file does the same
//   parser reset after its byte is processed.
module netpbm_stream_decoder_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nsd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nsd_pkg::t_out_item o_out_item
);
    import nsd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_DIGIT,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXLEV,
        PH_SAMPLES,
        PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        FMT_P1,
        FMT_P2,
        FMT_P3,
        FMT_P6
    } t_format;

    // where the scaler result goes
    typedef enum logic [1:0] {
        DST_GRAY,
        DST_RED,
        DST_GREEN,
        DST_BLUE
    } t_dest;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_EMIT
    } t_state;

    // control / parser state
    t_state           r_state;
    t_phase           r_phase,  n_phase;
    t_format          r_format, n_format;
    logic [DIM_W-1:0] r_width,  n_width;
    logic [DIM_W-1:0] r_height, n_height;
    logic [15:0]      r_max,    n_max;
    logic [16:0]      r_acc,    n_acc;
    logic             r_innum,  n_innum;
    logic [1:0]       r_comp,   n_comp;
    logic [DIM_W-1:0] r_row,    n_row;
    logic [DIM_W-1:0] r_col,    n_col;
    logic             r_out_valid;

    // payload
    logic [7:0]       r_held_red;
    logic [7:0]       r_held_green;
    t_out_item        r_pend;
    t_out_item        r_out_item;
    t_dest            r_dest;
    logic             r_ev;

    // per-byte decode
    logic             w_accept;
    logic             w_out_free;
    logic [7:0]       w_byte;
    logic             w_eof;
    logic             w_digit;
    logic [3:0]       w_dval;
    logic [20:0]      w_acc_sum;
    logic [16:0]      w_acc_next;
    logic [DIM_W-1:0] w_clamp;
    logic [15:0]      w_lev;
    logic             w_hit;
    logic [16:0]      w_sval;
    logic             w_pix_ok;
    logic             w_emit;
    logic [7:0]       w_gray;
    logic [DIM_W:0]   w_col_inc;
    logic [16:0]      w_row_ext;
    logic [16:0]      w_col_ext;
    logic             w_ev;
    logic             w_need_div;
    t_dest            w_dest;
    t_out_item        w_pend;

    t_scale_req       w_req;
    t_scale_rsp       w_rsp;

    assign w_byte     = i_in_item.data_byte;
    assign w_eof      = i_in_item.end_of_file;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_digit    = (w_byte > DIGIT_LOW) && (w_byte < DIGIT_HIGH);
    assign w_dval     = w_byte[3:0] - ASCII_ZERO[3:0];
    assign w_acc_sum  = 21'({r_acc, 3'b000}) + 21'({r_acc, 1'b0}) + 21'(w_dval);
    assign w_acc_next = ((r_acc > ACC_GUARD) || (w_acc_sum > 21'(ACC_MAX))) ?
                        ACC_MAX : w_acc_sum[16:0];
    assign w_clamp    = (r_acc > 17'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_acc);
    assign w_lev      = (r_acc > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : r_acc[15:0];

    assign w_pix_ok   = (r_width != '0) && (r_row < r_height);
    assign w_gray     = (w_sval == 17'd0) ? FULL_LEVEL : 8'd0;
    assign w_col_inc  = {1'b0, r_col} + (DIM_W + 1)'(1);
    assign w_row_ext  = 17'(r_row);
    assign w_col_ext  = 17'(r_col);

    always_comb begin
        n_phase    = r_phase;
        n_format   = r_format;
        n_width    = r_width;
        n_height   = r_height;
        n_max      = r_max;
        n_acc      = r_acc;
        n_innum    = r_innum;
        n_comp     = r_comp;
        n_row      = r_row;
        n_col      = r_col;
        w_ev       = 1'b0;
        w_hit      = 1'b0;
        w_sval     = 17'd0;
        w_emit     = 1'b0;
        w_need_div = 1'b0;
        w_dest     = DST_GRAY;
        w_pend     = '0;

        unique case (r_phase)
            PH_MAGIC: begin
                if (w_byte == ASCII_P) begin
                    n_phase = PH_DIGIT;
                end else begin
                    w_ev          = 1'b1;
                    w_pend.status = ST_BAD_MAGIC;
                    n_phase       = PH_HALT;
                end
            end
            PH_DIGIT: begin
                unique case (w_byte)
                    ASCII_ONE: begin
                        n_format = FMT_P1;
                        n_phase  = PH_WIDTH;
                    end
                    ASCII_TWO: begin
                        n_format = FMT_P2;
                        n_phase  = PH_WIDTH;
                    end
                    ASCII_THREE: begin
                        n_format = FMT_P3;
                        n_phase  = PH_WIDTH;
                    end
                    ASCII_SIX: begin
                        n_format = FMT_P6;
                        n_phase  = PH_WIDTH;
                    end
                    default: begin
                        w_ev          = 1'b1;
                        w_pend.status = ST_BAD_FORMAT;
                        n_phase       = PH_HALT;
                    end
                endcase
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXLEV, PH_SAMPLES: begin
                if (r_phase == PH_SAMPLES && r_format == FMT_P6) begin
                    // raw samples: every byte is a component
                    w_hit  = 1'b1;
                    w_sval = {9'd0, w_byte};
                end else begin
                    if (w_digit) begin
                        n_acc   = w_acc_next;
                        n_innum = 1'b1;
                    end else if (r_innum) begin
                        n_acc   = 17'd0;
                        n_innum = 1'b0;
                        unique case (r_phase)
                            PH_WIDTH: begin
                                n_width = w_clamp;
                                n_phase = PH_HEIGHT;
                            end
                            PH_HEIGHT: begin
                                n_height = w_clamp;
                                n_phase  = (r_format == FMT_P1) ? PH_SAMPLES : PH_MAXLEV;
                            end
                            PH_MAXLEV: begin
                                n_max = w_lev;
                                if (w_lev == 16'd0) begin
                                    w_ev          = 1'b1;
                                    w_pend.status = ST_ZERO_LEVEL;
                                    n_phase       = PH_HALT;
                                end else begin
                                    n_phase = PH_SAMPLES;
                                end
                            end
                            default: begin
                                w_hit  = 1'b1;
                                w_sval = r_acc;
                            end
                        endcase
                    end
                    // end of file finishes a sample number still being read
                    if (w_eof && n_phase == PH_SAMPLES && n_innum) begin
                        w_hit  = 1'b1;
                        w_sval = n_acc;
                    end
                end
            end
            default: ;
        endcase

        if (w_hit) begin
            unique case (r_format)
                FMT_P1: begin
                    w_emit       = w_pix_ok;
                    w_pend.red   = w_gray;
                    w_pend.green = w_gray;
                    w_pend.blue  = w_gray;
                end
                FMT_P2: begin
                    w_emit     = w_pix_ok;
                    w_need_div = w_pix_ok;
                    w_dest     = DST_GRAY;
                end
                default: begin
                    unique case (r_comp)
                        2'd0: begin
                            n_comp     = 2'd1;
                            w_need_div = !w_eof;
                            w_dest     = DST_RED;
                        end
                        2'd1: begin
                            n_comp     = 2'd2;
                            w_need_div = !w_eof;
                            w_dest     = DST_GREEN;
                        end
                        default: begin
                            n_comp       = 2'd0;
                            w_emit       = w_pix_ok;
                            w_need_div   = w_pix_ok;
                            w_dest       = DST_BLUE;
                            w_pend.red   = r_held_red;
                            w_pend.green = r_held_green;
                        end
                    endcase
                end
            endcase
        end

        if (w_emit) begin
            w_ev          = 1'b1;
            w_pend.row    = w_row_ext[11:0];
            w_pend.column = w_col_ext[11:0];
            if (w_col_inc >= {1'b0, r_width}) begin
                n_col = '0;
                n_row = r_row + DIM_W'(1);
            end else begin
                n_col = w_col_inc[DIM_W-1:0];
            end
        end

        if (w_eof) begin
            n_phase  = PH_MAGIC;
            n_format = FMT_P1;
            n_width  = '0;
            n_height = '0;
            n_max    = 16'd0;
            n_acc    = 17'd0;
            n_innum  = 1'b0;
            n_comp   = 2'd0;
            n_row    = '0;
            n_col    = '0;
        end
    end

    // shared scaler, started on the accept edge with the current level
    always_comb begin
        w_req.start  = w_accept && w_need_div;
        w_req.sample = w_sval;
        w_req.level  = r_max;
    end

    nsd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= PH_MAGIC;
            r_format    <= FMT_P1;
            r_width     <= '0;
            r_height    <= '0;
            r_max       <= 16'd0;
            r_acc       <= 17'd0;
            r_innum     <= 1'b0;
            r_comp      <= 2'd0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_phase  <= n_phase;
                        r_format <= n_format;
                        r_width  <= n_width;
                        r_height <= n_height;
                        r_max    <= n_max;
                        r_acc    <= n_acc;
                        r_innum  <= n_innum;
                        r_comp   <= n_comp;
                        r_row    <= n_row;
                        r_col    <= n_col;
                        r_ev     <= w_ev;
                        r_dest   <= w_dest;
                        r_pend   <= w_pend;
                        if (w_need_div) begin
                            r_state <= S_SCALE;
                        end else if (w_ev) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_SCALE: begin
                    if (w_rsp.done) begin
                        unique case (r_dest)
                            DST_GRAY: begin
                                r_pend.red   <= w_rsp.value;
                                r_pend.green <= w_rsp.value;
                                r_pend.blue  <= w_rsp.value;
                            end
                            DST_RED:   r_held_red   <= w_rsp.value;
                            DST_GREEN: r_held_green <= w_rsp.value;
                            DST_BLUE:  r_pend.blue  <= w_rsp.value;
                        endcase
                        r_state <= r_ev ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_pend;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ design/nsd_checker.sv @@
// Port-level checker for the netpbm stream decoder, bound to the top level.
module nsd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input nsd_pkg::t_out_item o_out_item
);
    import nsd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset returns the parser to idle, ready for a byte
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // error results carry no position or color
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_PIXEL |->
        o_out_item.row == 12'd0 && o_out_item.column == 12'd0 &&
        o_out_item.red == 8'd0 && o_out_item.green == 8'd0 && o_out_item.blue == 8'd0)
        else $error("error result with nonzero payload");

    // a stalled result keeps its whole payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("result payload changed while stalled");

endmodule

bind netpbm_stream_decoder_unit nsd_checker u_nsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ tb/tb.sv @@
// Self-checking testbench for netpbm_stream_decoder_unit: random netpbm files in, RGB pixels and error results out.
`timescale 1ns / 100ps

module tb;
    import nsd_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 40;

    // parser phases and formats of the predictor
    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_FMT_DIGIT,
        PH_WIDTH,
        PH_HEIGHT,
        PH_LEVEL,
        PH_SAMPLES,
        PH_HALT
    } t_parse_phase;

    typedef enum logic [1:0] {
        FMT_BITMAP,
        FMT_GRAY,
        FMT_COLOR,
        FMT_RAW
    } t_format;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;

    // file bytes waiting for the driver, decoded results waiting for the DUT
    t_in_item   file_bytes[$];
    t_out_item  decoded_q[$];

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         holds_asked   = 0;
    int         holds_granted = 0;
    int         hold_left     = 0;
    int         mismatch_count = 0;
    int         byte_count    = 0;
    bit         junk          = 1'b0;

    // predictor state
    t_parse_phase pr_phase;
    t_format      pr_format;
    logic [12:0]  pr_width;
    logic [12:0]  pr_height;
    logic [15:0]  pr_level;
    logic [16:0]  pr_acc;
    logic         pr_in_number;
    logic [1:0]   pr_comp;
    logic [7:0]   pr_red;
    logic [7:0]   pr_green;
    logic [12:0]  pr_row;
    logic [12:0]  pr_col;

    netpbm_stream_decoder_unit #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void reset_parser();
        pr_phase     = PH_MAGIC;
        pr_format    = FMT_BITMAP;
        pr_width     = '0;
        pr_height    = '0;
        pr_level     = '0;
        pr_acc       = '0;
        pr_in_number = 1'b0;
        pr_comp      = '0;
        pr_red       = '0;
        pr_green     = '0;
        pr_row       = '0;
        pr_col       = '0;
    endfunction

    function automatic logic [12:0] clamp_dim(int unsigned v);
        return (v > MAX_DIM) ? 13'(MAX_DIM) : v[12:0];
    endfunction

    function automatic logic [7:0] scale_level(int unsigned v);
        int unsigned q;
        if (pr_level == 0 || v > pr_level)
            return FULL_LEVEL;
        q = (v * 255) / pr_level;
        return q[7:0];
    endfunction

    function automatic bit raise_error(t_status code);
        t_out_item e;
        e        = '0;
        e.status = code;
        decoded_q.push_back(e);
        pr_phase = PH_HALT;
        return 1'b1;
    endfunction

    // pixels beyond the last row, or any pixel of a zero-width image, vanish
    function automatic bit place_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_out_item e;
        if (pr_width == 0 || pr_row >= pr_height)
            return 1'b0;
        e.status = ST_PIXEL;
        e.row    = pr_row[11:0];
        e.column = pr_col[11:0];
        e.red    = r;
        e.green  = g;
        e.blue   = b;
        decoded_q.push_back(e);
        pr_col = pr_col + 1'b1;
        if (pr_col >= pr_width) begin
            pr_col = '0;
            pr_row = pr_row + 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic bit take_component(logic [7:0] c);
        if (pr_comp == 0) begin
            pr_red  = c;
            pr_comp = 2'd1;
            return 1'b0;
        end
        if (pr_comp == 1) begin
            pr_green = c;
            pr_comp  = 2'd2;
            return 1'b0;
        end
        pr_comp = '0;
        return place_pixel(pr_red, pr_green, c);
    endfunction

    function automatic bit finish_sample(int unsigned v);
        logic [7:0] g;
        if (pr_format == FMT_BITMAP) begin
            g = (v == 0) ? FULL_LEVEL : 8'd0;
            return place_pixel(g, g, g);
        end
        if (pr_format == FMT_GRAY) begin
            g = scale_level(v);
            return place_pixel(g, g, g);
        end
        return take_component(scale_level(v));
    endfunction

    // one accepted file byte through the predictor
    function automatic void decode_byte(t_in_item it);
        logic [7:0]  b;
        bit          eof;
        bit          is_digit;
        bit          emitted;
        int unsigned acc_next;
        int unsigned v;
        b        = it.data_byte;
        eof      = it.end_of_file;
        is_digit = (b > DIGIT_LOW) && (b < DIGIT_HIGH);
        emitted  = 1'b0;
        if (pr_phase == PH_MAGIC) begin
            if (b == ASCII_P)
                pr_phase = PH_FMT_DIGIT;
            else
                emitted = raise_error(ST_BAD_MAGIC);
        end else if (pr_phase == PH_FMT_DIGIT) begin
            case (b)
                ASCII_ONE: begin
                    pr_format = FMT_BITMAP;
                    pr_phase  = PH_WIDTH;
                end
                ASCII_TWO: begin
                    pr_format = FMT_GRAY;
                    pr_phase  = PH_WIDTH;
                end
                ASCII_THREE: begin
                    pr_format = FMT_COLOR;
                    pr_phase  = PH_WIDTH;
                end
                ASCII_SIX: begin
                    pr_format = FMT_RAW;
                    pr_phase  = PH_WIDTH;
                end
                default: emitted = raise_error(ST_BAD_FORMAT);
            endcase
        end else if (pr_phase == PH_SAMPLES && pr_format == FMT_RAW) begin
            emitted = take_component(scale_level(32'(b)));
        end else if (pr_phase >= PH_WIDTH && pr_phase <= PH_SAMPLES) begin
            if (is_digit) begin
                acc_next = 32'(pr_acc) * 10 + 32'(b - ASCII_ZERO);
                if (pr_acc > ACC_GUARD || acc_next > ACC_MAX)
                    acc_next = ACC_MAX;
                pr_acc       = acc_next[16:0];
                pr_in_number = 1'b1;
            end else if (pr_in_number) begin
                v            = 32'(pr_acc);
                pr_acc       = '0;
                pr_in_number = 1'b0;
                case (pr_phase)
                    PH_WIDTH: begin
                        pr_width = clamp_dim(v);
                        pr_phase = PH_HEIGHT;
                    end
                    PH_HEIGHT: begin
                        pr_height = clamp_dim(v);
                        pr_phase  = (pr_format == FMT_BITMAP) ? PH_SAMPLES : PH_LEVEL;
                    end
                    PH_LEVEL: begin
                        pr_level = (v > LEVEL_MAX) ? LEVEL_MAX : v[15:0];
                        if (pr_level == 0)
                            emitted = raise_error(ST_ZERO_LEVEL);
                        else
                            pr_phase = PH_SAMPLES;
                    end
                    default: emitted = finish_sample(v);
                endcase
            end
            // end of file finishes a sample number still being read
            if (eof && pr_phase == PH_SAMPLES && pr_in_number && !emitted)
                emitted = finish_sample(32'(pr_acc));
        end
        if (eof)
            reset_parser();
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            reset_parser();
        end else begin
            if (in_valid && !in_stall)
                decode_byte(in_item);
            // a new byte may be offered once the current one is taken
            if (!in_valid || !in_stall) begin
                if (file_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item  <= file_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none actual %p",
                             $time, out_item);
                    mismatch_count++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(out_item.status));
                    compare_field("row",    32'(want.row),    32'(out_item.row));
                    compare_field("column", 32'(want.column), 32'(out_item.column));
                    compare_field("red",    32'(want.red),    32'(out_item.red));
                    compare_field("green",  32'(want.green),  32'(out_item.green));
                    compare_field("blue",   32'(want.blue),   32'(out_item.blue));
                end
            end
            // a requested long hold-off overrides the random stalls
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (holds_granted != holds_asked) begin
                out_stall     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                holds_granted <= holds_granted + 1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------- file builder

    function automatic void put_byte(logic [7:0] b, bit eof);
        t_in_item it;
        it.data_byte   = b;
        it.end_of_file = eof;
        file_bytes.push_back(it);
        if (!junk)
            byte_count++;
    endfunction

    function automatic void mark_eof();
        t_in_item it;
        it             = file_bytes.pop_back();
        it.end_of_file = 1'b1;
        file_bytes.push_back(it);
    endfunction

    function automatic logic [7:0] any_separator();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: b = 8'h20;
            1: b = 8'h0A;
            2: b = 8'h09;
            3: b = 8'h0D;
            default: begin
                b = 8'($urandom_range(0, 255));
                if (b > DIGIT_LOW && b < DIGIT_HIGH)
                    b = 8'h23;
            end
        endcase
        return b;
    endfunction

    function automatic void put_gap();
        repeat ($urandom_range(1, 3))
            put_byte(any_separator(), 1'b0);
    endfunction

    function automatic void put_number(int unsigned v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            put_byte(ASCII_ZERO, 1'b0);
        for (i = 0; i < s.len(); i++)
            put_byte(s[i], 1'b0);
    endfunction

    function automatic int unsigned pick_dim(int unsigned usual_max);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(4000, 200000);
            default: return $urandom_range(1, usual_max);
        endcase
    endfunction

    function automatic int unsigned pick_sample(t_format fmt, int unsigned top);
        if (fmt == FMT_BITMAP) begin
            case ($urandom_range(0, 4))
                0: return $urandom_range(2, 99);
                1, 2: return 1;
                default: return 0;
            endcase
        end
        case ($urandom_range(0, 9))
            0: return 0;
            1: return top;
            2: return top + $urandom_range(1, 9);
            3: return $urandom_range(131072, 9999999);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // one well-formed file with random content; sometimes short or long on samples
    function automatic void put_image();
        t_format     fmt;
        int unsigned w, h, lvl, top, pix, comps, total, k;
        fmt = t_format'($urandom_range(0, 3));
        put_byte(ASCII_P, 1'b0);
        case (fmt)
            FMT_BITMAP: put_byte(ASCII_ONE, 1'b0);
            FMT_GRAY:   put_byte(ASCII_TWO, 1'b0);
            FMT_COLOR:  put_byte(ASCII_THREE, 1'b0);
            default:    put_byte(ASCII_SIX, 1'b0);
        endcase
        w = pick_dim(6);
        h = pick_dim(4);
        put_gap();
        put_number(w);
        put_gap();
        put_number(h);
        lvl = 1;
        if (fmt != FMT_BITMAP) begin
            case ($urandom_range(0, 7))
                0: lvl = 1;
                1: lvl = 255;
                2: lvl = $urandom_range(65535, 200000);
                3: lvl = $urandom_range(2, 15);
                default: lvl = $urandom_range(1, 65535);
            endcase
            put_gap();
            put_number(lvl);
        end
        top = (lvl > 65535) ? 65535 : lvl;
        // raw samples start right after the one byte ending the level
        if (fmt == FMT_RAW)
            put_byte(any_separator(), 1'b0);
        else
            put_gap();
        if (w == 0 || h == 0)
            pix = $urandom_range(0, 3);
        else if (w <= 6 && h <= 4)
            pix = w * h;
        else
            pix = $urandom_range(1, 8);
        comps = (fmt == FMT_COLOR || fmt == FMT_RAW) ? 3 : 1;
        total = pix * comps;
        case ($urandom_range(0, 5))
            0: total = total + comps * $urandom_range(1, 3);
            1: if (total > 0) total = total - $urandom_range(1, (total < comps) ? total : comps);
            default: ;
        endcase
        for (k = 0; k < total; k++) begin
            if (fmt == FMT_RAW) begin
                put_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                put_number(pick_sample(fmt, top));
                if (k + 1 < total)
                    put_gap();
            end
        end
        if (fmt == FMT_RAW || (total > 0 && $urandom_range(0, 1) == 0))
            mark_eof();
        else
            put_byte(any_separator(), 1'b1);
    endfunction

    // error files, headers cut short by end of file, and plain noise
    function automatic void put_broken();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: begin
                b = 8'($urandom_range(0, 255));
                if (b == ASCII_P)
                    b = b + 1'b1;
                put_byte(b, 1'b0);
            end
            1: begin
                put_byte(ASCII_P, 1'b0);
                b = 8'($urandom_range(0, 255));
                if (b == ASCII_ONE || b == ASCII_TWO || b == ASCII_THREE || b == ASCII_SIX)
                    b = 8'h35;
                put_byte(b, 1'b0);
            end
            2: begin
                put_byte(ASCII_P, 1'b0);
                case ($urandom_range(0, 2))
                    0: put_byte(ASCII_TWO, 1'b0);
                    1: put_byte(ASCII_THREE, 1'b0);
                    default: put_byte(ASCII_SIX, 1'b0);
                endcase
                put_gap();
                put_number($urandom_range(1, 4));
                put_gap();
                put_number($urandom_range(1, 4));
                put_gap();
                repeat ($urandom_range(1, 3))
                    put_byte(ASCII_ZERO, 1'b0);
                put_byte(any_separator(), 1'b0);
            end
            3: begin
                put_byte(ASCII_P, 1'b0);
                put_byte(ASCII_ONE + 8'($urandom_range(0, 1)), 1'b0);
                put_gap();
                put_number($urandom_range(0, 99999));
                if ($urandom_range(0, 1) == 0) begin
                    put_gap();
                    put_number($urandom_range(0, 999));
                end
            end
            default: begin
                repeat ($urandom_range(1, 6))
                    put_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        endcase
        // whatever follows an error is skipped by the block
        junk = 1'b1;
        repeat ($urandom_range(0, 4))
            put_byte(8'($urandom_range(0, 255)), 1'b0);
        junk = 1'b0;
        mark_eof();
    endfunction

    // ---------------------------------------------------------------- sequencing

    task automatic wait_sent();
        while (file_bytes.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    task automatic build_random(int unsigned count);
        int unsigned start;
        start = byte_count;
        while (byte_count - start < count) begin
            if ($urandom_range(0, 99) < 85)
                put_image();
            else
                put_broken();
        end
    endtask

    initial begin
        int cycles;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extreme byte as bad magic, unknown format digit,
        // P1 with end of file on the last digit, P6 with saturation
        put_byte(8'hFF, 1'b1);
        put_byte(ASCII_P, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(ASCII_P, 1'b0);
        put_byte(ASCII_ONE, 1'b0);
        put_number(2);
        put_byte(8'h20, 1'b0);
        put_number(1);
        put_byte(8'h0A, 1'b0);
        put_byte(ASCII_ZERO, 1'b0);
        put_byte(8'h20, 1'b0);
        put_byte(ASCII_ONE, 1'b1);
        put_byte(ASCII_P, 1'b0);
        put_byte(ASCII_SIX, 1'b0);
        put_byte(ASCII_ONE, 1'b0);
        put_byte(8'h20, 1'b0);
        put_byte(ASCII_ONE, 1'b0);
        put_byte(8'h20, 1'b0);
        put_byte(8'h39, 1'b0);
        put_byte(8'h0A, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h04, 1'b1);

        // sender stops until the block has delivered everything
        wait_sent();
        while (decoded_q.size() != 0)
            @(negedge clk);

        send_idle_pct = 34;
        recv_idle_pct = 60;
        build_random(700);
        wait_sent();

        send_idle_pct = 60;
        recv_idle_pct = 34;
        build_random(700);
        wait_sent();

        // no idling, but one long receiver hold-off so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        build_random(600);
        holds_asked++;
        wait_sent();

        cycles = 0;
        while (decoded_q.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(negedge clk);
            cycles++;
        end
        repeat (SETTLE) @(negedge clk);
        if (decoded_q.size() != 0) begin
            $display("%0t: %0d results expected, actual none", $time, decoded_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
design/nsd_pkg.sv
design/nsd_scale.sv
design/netpbm_stream_decoder_unit.sv
design/nsd_checker.sv
tb/tb.sv
